[rtl/irpdt_pkg.sv]
package irpdt_pkg;

    // Request codes carried in s_tuser
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_LOAD     = 3'd1;
    localparam logic [2:0] REQ_TRANSMIT = 3'd2;
    localparam logic [2:0] REQ_REPEAT   = 3'd3;
    localparam logic [2:0] REQ_DELAY    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_BIT_COUNT    = 3'd0;
    localparam logic [2:0] CFG_START        = 3'd1;
    localparam logic [2:0] CFG_STOP         = 3'd2;
    localparam logic [2:0] CFG_ZERO         = 3'd3;
    localparam logic [2:0] CFG_ONE          = 3'd4;
    localparam logic [2:0] CFG_REPEAT_START = 3'd5;
    localparam logic [2:0] CFG_REPEAT_STOP  = 3'd6;

    // Reset timings: mark ticks [31:16], space ticks [15:0]
    localparam logic [7:0]  RST_BIT_COUNT    = 8'd32;
    localparam logic [31:0] RST_START        = {16'd684, 16'd342};
    localparam logic [31:0] RST_STOP         = {16'd42, 16'd1710};
    localparam logic [31:0] RST_ZERO         = {16'd42, 16'd42};
    localparam logic [31:0] RST_ONE          = {16'd42, 16'd126};
    localparam logic [31:0] RST_REPEAT_START = {16'd684, 16'd171};
    localparam logic [31:0] RST_REPEAT_STOP  = {16'd42, 16'd3800};

    // One mark/space pair
    typedef struct packed {
        logic [15:0] mark;
        logic [15:0] space;
    } pair_t;

endpackage

[rtl/irpdt_ram.sv]
module irpdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/ir_pulse_distance_transmitter_core.sv]
// Result: each accepted request's result is registered and shows on the master side
// in the next cycle. Throughput: one request per cycle unless the result side stalls;
// the countdown and the code store read (from the next bit position) keep up with ticks.
// Reset: rst_n clears the framer to idle, the gate off and the timing registers
// to their defaults; the code store holds undefined data until loaded.
module ir_pulse_distance_transmitter_core
    import irpdt_pkg::*;
#(
    parameter int CODE_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_index[4:0], byte_value[12:5], delay_ticks[28:13]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // carrier_gate[0], busy_res[1]
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;
    localparam logic [5:0] DEPTH_W = 6'(CODE_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_REP_START,
        PH_REP_END,
        PH_DELAY,
        PH_DELAY_END
    } phase_t;

    // Configuration registers
    logic [7:0] bit_count_reg;
    pair_t      start_reg, stop_reg, zero_reg, one_reg, rep_start_reg, rep_stop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= RST_BIT_COUNT;
            start_reg     <= RST_START;
            stop_reg      <= RST_STOP;
            zero_reg      <= RST_ZERO;
            one_reg       <= RST_ONE;
            rep_start_reg <= RST_REPEAT_START;
            rep_stop_reg  <= RST_REPEAT_STOP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_COUNT:    bit_count_reg <= cfg_wdata[7:0];
                CFG_START:        start_reg     <= cfg_wdata;
                CFG_STOP:         stop_reg      <= cfg_wdata;
                CFG_ZERO:         zero_reg      <= cfg_wdata;
                CFG_ONE:          one_reg       <= cfg_wdata;
                CFG_REPEAT_START: rep_start_reg <= cfg_wdata;
                CFG_REPEAT_STOP:  rep_stop_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Request fields
    logic [2:0]  req_type;
    logic [4:0]  byte_index;
    logic [7:0]  byte_value;
    logic [15:0] delay_ticks;

    assign req_type    = s_tuser;
    assign byte_index  = s_tdata[4:0];
    assign byte_value  = s_tdata[12:5];
    assign delay_ticks = s_tdata[28:13];

    // Framer state
    phase_t      phase_reg, phase_next;
    logic [15:0] mark_reg, mark_next;
    logic [15:0] space_reg, space_next;
    logic [7:0]  bit_index_reg, bit_index_next;
    logic [7:0]  bit_shift_reg, bit_shift_next;
    logic        gate_reg, gate_next;
    logic [15:0] delay_len_reg, delay_len_next;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic s_fire;
    logic busy;
    logic busy_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign busy     = (phase_reg != PH_IDLE) || (mark_reg != 16'd0) || (space_reg != 16'd0);

    // Code store with forwarding of a write to the address being read
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [4:0]    rd_byte;
    logic          rd_oob_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    code_byte;

    assign ram_we    = s_fire && (req_type == REQ_LOAD) && ({1'b0, byte_index} < DEPTH_W);
    assign ram_waddr = AW'(byte_index);
    assign rd_byte   = bit_index_next[7:3];
    assign ram_raddr = AW'(rd_byte);

    irpdt_ram #(
        .WIDTH (8),
        .DEPTH (CODE_BYTES)
    ) u_code_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_oob_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_oob_reg  <= ({1'b0, rd_byte} >= DEPTH_W);
            fwd_hit_reg <= ram_we && (byte_index == rd_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= byte_value;
    end

    assign code_byte = rd_oob_reg ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : ram_rdata);

    // Next state for the accepted request
    always_comb
    begin
        logic [7:0] sh;
        pair_t      bit_pair;

        phase_next     = phase_reg;
        mark_next      = mark_reg;
        space_next     = space_reg;
        bit_index_next = bit_index_reg;
        bit_shift_next = bit_shift_reg;
        gate_next      = gate_reg;
        delay_len_next = delay_len_reg;
        sh             = (bit_index_reg[2:0] == 3'd0) ? code_byte : bit_shift_reg;
        bit_pair       = sh[0] ? one_reg : zero_reg;

        if (s_fire)
        begin
            case (req_type)
                REQ_TICK:
                begin
                    // countdown: mark first, then space
                    if (mark_next != 16'd0)
                    begin
                        mark_next = mark_next - 16'd1;
                        if (mark_next == 16'd0)
                        begin
                            gate_next = 1'b0;
                        end
                    end
                    else if (space_next != 16'd0)
                    begin
                        space_next = space_next - 16'd1;
                    end
                    // space done: load the next pair
                    if (space_next == 16'd0)
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                {mark_next, space_next} = start_reg;
                                phase_next     = PH_DATA;
                                bit_index_next = 8'd0;
                            end
                            PH_DATA:
                            begin
                                if (bit_index_reg < bit_count_reg)
                                begin
                                    {mark_next, space_next} = bit_pair;
                                    bit_shift_next = sh >> 1;
                                    bit_index_next = bit_index_reg + 8'd1;
                                end
                                else
                                begin
                                    {mark_next, space_next} = stop_reg;
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_REP_START:
                            begin
                                {mark_next, space_next} = rep_start_reg;
                                phase_next = PH_REP_END;
                            end
                            PH_REP_END:
                            begin
                                {mark_next, space_next} = rep_stop_reg;
                                phase_next = PH_IDLE;
                            end
                            PH_DELAY:
                            begin
                                mark_next  = 16'd0;
                                space_next = delay_len_reg;
                                phase_next = PH_DELAY_END;
                            end
                            default:
                            begin
                                mark_next  = 16'd0;
                                space_next = 16'd0;
                                phase_next = PH_IDLE;
                            end
                        endcase
                        if (mark_next != 16'd0)
                        begin
                            gate_next = 1'b1;
                        end
                    end
                end
                REQ_TRANSMIT:
                begin
                    if (!busy)
                    begin
                        phase_next = PH_START;
                    end
                end
                REQ_REPEAT:
                begin
                    if (!busy)
                    begin
                        phase_next = PH_REP_START;
                    end
                end
                REQ_DELAY:
                begin
                    if (!busy)
                    begin
                        delay_len_next = delay_ticks;
                        phase_next     = PH_DELAY;
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy_next = (phase_next != PH_IDLE) || (mark_next != 16'd0) ||
                       (space_next != 16'd0);

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mark_reg      <= 16'd0;
            space_reg     <= 16'd0;
            bit_index_reg <= 8'd0;
            bit_shift_reg <= 8'd0;
            gate_reg      <= 1'b0;
            delay_len_reg <= 16'd0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mark_reg      <= mark_next;
            space_reg     <= space_next;
            bit_index_reg <= bit_index_next;
            bit_shift_reg <= bit_shift_next;
            gate_reg      <= gate_next;
            delay_len_reg <= delay_len_next;
            if (s_fire)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {6'd0, busy_next, gate_next};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A pending result reports the busy state the framer still holds
    a_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[1] == busy))
        else $error("result busy flag disagrees with framer state");

    // A running mark always has the carrier gated on
    a_mark_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_reg != 16'd0) |-> gate_reg)
        else $error("mark counting with carrier gate off");

    // A transmit accepted while idle enters the start phase
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (req_type == REQ_TRANSMIT) && !busy) |=> (phase_reg == PH_START))
        else $error("transmit from idle did not start a frame");

endmodule

[tb/tb_ir_pulse_distance_transmitter_core.sv]
module tb_ir_pulse_distance_transmitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import irpdt_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CODE_BYTES  = 32;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam int SEG_ITEMS   = 40;

    // request codes the block leaves undefined
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_START,
        FR_DATA,
        FR_REP_START,
        FR_REP_STOP,
        FR_DELAY,
        FR_DELAY_END
    } frame_phase_t;

    typedef struct packed {
        logic busy;
        logic gate;
    } emitter_out_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // idling rates in percent, and a one-shot receiver hold-off request
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_len;
    int mismatch_count;

    // values about to be written to the register file
    logic [31:0] reg_image [7];

    // emitter predictor state
    frame_phase_t frame_ph;
    logic [15:0]  mark_cnt;
    logic [15:0]  space_cnt;
    logic [15:0]  delay_len;
    logic [7:0]   bit_pos;
    logic [7:0]   bit_sr;
    logic [7:0]   bit_count_cfg;
    logic [7:0]   code_img [CODE_BYTES];
    logic         carrier_on;
    pair_t        pair_cfg [7];
    emitter_out_t emitter_out_q [$];

    // handshakes sampled at the falling edge, used at the next rising edge
    bit         in_fire_n;
    bit         out_fire_n;
    logic [7:0] out_word_n;

    ir_pulse_distance_transmitter_core #(
        .CODE_BYTES(CODE_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit framer_busy();
        return frame_ph != FR_IDLE || mark_cnt != 16'd0 || space_cnt != 16'd0;
    endfunction

    function automatic void load_pair(input pair_t p);
        mark_cnt  = p.mark;
        space_cnt = p.space;
    endfunction

    // next mark/space pair for the current frame phase
    function automatic void advance_pair();
        case (frame_ph)
            FR_START:
            begin
                load_pair(pair_cfg[CFG_START]);
                frame_ph = FR_DATA;
                bit_pos  = 8'd0;
            end
            FR_DATA:
            begin
                if (bit_pos < bit_count_cfg)
                begin
                    if (bit_pos[2:0] == 3'd0)
                        bit_sr = code_img[bit_pos[7:3]];
                    load_pair(bit_sr[0] ? pair_cfg[CFG_ONE] : pair_cfg[CFG_ZERO]);
                    bit_sr  = bit_sr >> 1;
                    bit_pos = bit_pos + 8'd1;
                end
                else
                begin
                    load_pair(pair_cfg[CFG_STOP]);
                    frame_ph = FR_IDLE;
                end
            end
            FR_REP_START:
            begin
                load_pair(pair_cfg[CFG_REPEAT_START]);
                frame_ph = FR_REP_STOP;
            end
            FR_REP_STOP:
            begin
                load_pair(pair_cfg[CFG_REPEAT_STOP]);
                frame_ph = FR_IDLE;
            end
            FR_DELAY:
            begin
                mark_cnt  = 16'd0;
                space_cnt = delay_len;
                frame_ph  = FR_DELAY_END;
            end
            default:
            begin
                mark_cnt  = 16'd0;
                space_cnt = 16'd0;
                frame_ph  = FR_IDLE;
            end
        endcase
    endfunction

    // one tick of the mark/space countdown
    function automatic void tick_countdown();
        if (mark_cnt != 16'd0)
        begin
            mark_cnt = mark_cnt - 16'd1;
            if (mark_cnt == 16'd0)
                carrier_on = 1'b0;
        end
        else if (space_cnt != 16'd0)
            space_cnt = space_cnt - 16'd1;
        if (space_cnt == 16'd0)
        begin
            advance_pair();
            if (mark_cnt != 16'd0)
                carrier_on = 1'b1;
        end
    endfunction

    function automatic void reset_emitter_model();
        frame_ph      = FR_IDLE;
        mark_cnt      = 16'd0;
        space_cnt     = 16'd0;
        delay_len     = 16'd0;
        bit_pos       = 8'd0;
        bit_sr        = 8'd0;
        carrier_on    = 1'b0;
        bit_count_cfg = RST_BIT_COUNT;
        pair_cfg[CFG_START]        = RST_START;
        pair_cfg[CFG_STOP]         = RST_STOP;
        pair_cfg[CFG_ZERO]         = RST_ZERO;
        pair_cfg[CFG_ONE]          = RST_ONE;
        pair_cfg[CFG_REPEAT_START] = RST_REPEAT_START;
        pair_cfg[CFG_REPEAT_STOP]  = RST_REPEAT_STOP;
    endfunction

    function automatic void store_cfg(input logic [2:0] idx, input logic [31:0] val);
        if (idx == CFG_BIT_COUNT)
            bit_count_cfg = val[7:0];
        else
            pair_cfg[idx] = val;
    endfunction

    // update the model for one accepted request and queue its result
    function automatic void apply_request(input logic [2:0] kind, input logic [4:0] idx,
                                          input logic [7:0] val, input logic [15:0] dly);
        emitter_out_t res;
        case (kind)
            REQ_TICK:     tick_countdown();
            REQ_LOAD:     code_img[idx] = val;
            REQ_TRANSMIT: if (!framer_busy()) frame_ph = FR_START;
            REQ_REPEAT:   if (!framer_busy()) frame_ph = FR_REP_START;
            REQ_DELAY:
            begin
                if (!framer_busy())
                begin
                    delay_len = dly;
                    frame_ph  = FR_DELAY;
                end
            end
            default: ;
        endcase
        res.gate = carrier_on;
        res.busy = framer_busy();
        emitter_out_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
    endfunction

    function automatic void check_emitter_out(input logic [7:0] word);
        emitter_out_t want;
        if (emitter_out_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result transaction with none expected, m_tdata=%h",
                         $time, word);
        end
        else
        begin
            want = emitter_out_q.pop_front();
            if (word[0] !== want.gate)
                note_mismatch("carrier_gate", want.gate, word[0]);
            if (word[1] !== want.busy)
                note_mismatch("busy_res", want.busy, word[1]);
        end
    endfunction

    always @(negedge clk)
    begin
        in_fire_n  = rst_n && s_tvalid && s_tready;
        out_fire_n = rst_n && m_tvalid && m_tready;
        out_word_n = m_tdata;
    end

    always @(posedge clk)
    begin
        if (out_fire_n)
            check_emitter_out(out_word_n);
    end

    // result side: random ready, with an occasional long hold-off
    initial
    begin : result_sink
        int held;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                held = hold_off_len;
                hold_off_len = 0;
                m_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ends the run when no transaction moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (in_fire_n || out_fire_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_ir_pulse_distance_transmitter_core: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all start and end on a rising edge)
    // ------------------------------------------------------------------
    task automatic send_req(input logic [2:0] kind, input logic [4:0] idx,
                            input logic [7:0] val, input logic [15:0] dly);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, dly, val, idx};
        s_tuser  <= kind;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end while (!took);
        apply_request(kind, idx, val, dly);
    endtask

    // request with don't-care fields filled at random
    task automatic send_kind(input logic [2:0] kind);
        send_req(kind, 5'($urandom_range(31)), 8'($urandom_range(255)),
                 16'($urandom_range(65535)));
    endtask

    task automatic run_out_frame();
        while (framer_busy())
            send_kind(REQ_TICK);
    endtask

    // finish any frame, then wait until every result is back
    task automatic settle_framer();
        run_out_frame();
        s_tvalid <= 1'b0;
        while (emitter_out_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs();
        for (int i = CFG_BIT_COUNT; i <= CFG_REPEAT_STOP; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= reg_image[i];
            @(posedge clk);
            store_cfg(i[2:0], reg_image[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_random_timings();
        int pick;
        logic [15:0] mk;
        logic [15:0] sp;
        pick = $urandom_range(9);
        if (pick == 0)
            reg_image[CFG_BIT_COUNT] = 32'd0;
        else
            reg_image[CFG_BIT_COUNT] = $urandom_range(40, 1);
        for (int i = CFG_START; i <= CFG_REPEAT_STOP; i++)
        begin
            mk = 16'($urandom_range(4));
            sp = 16'($urandom_range(4));
            reg_image[i] = {mk, sp};
        end
    endtask

    // mostly well-formed frames with random content, plus loads and noise
    task automatic run_random_items(input int n_items);
        int done;
        int pick;
        logic [2:0] kind;
        logic [15:0] dly;
        bit counts;
        done = 0;
        while (done < n_items)
        begin
            pick   = $urandom_range(99);
            dly    = 16'($urandom_range(65535));
            counts = 1'b1;
            if (!framer_busy())
            begin
                if (pick < 30)
                    kind = REQ_TRANSMIT;
                else if (pick < 45)
                    kind = REQ_REPEAT;
                else if (pick < 55)
                begin
                    kind = REQ_DELAY;
                    dly  = ($urandom_range(49) == 0) ? 16'($urandom_range(400))
                                                     : 16'($urandom_range(12));
                end
                else if (pick < 62)
                    kind = REQ_LOAD;
                else if (pick < 66)
                begin
                    kind   = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
                    counts = 1'b0;
                end
                else
                    kind = REQ_TICK;
            end
            else
            begin
                if (pick < 80)
                    kind = REQ_TICK;
                else if (pick < 88)
                    kind = REQ_LOAD;
                else if (pick < 97)
                begin
                    // start of any kind while busy: dropped by the block
                    kind   = 3'($urandom_range(REQ_DELAY, REQ_TRANSMIT));
                    counts = 1'b0;
                end
                else
                begin
                    kind   = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
                    counts = 1'b0;
                end
            end
            send_req(kind, 5'($urandom_range(31)), 8'($urandom_range(255)), dly);
            if (counts)
                done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // short timings: full transmit, repeat and delay frames
    task automatic test_default_frames();
        reg_image[CFG_BIT_COUNT]    = 32'd32;
        reg_image[CFG_START]        = {16'd3, 16'd2};
        reg_image[CFG_STOP]         = {16'd2, 16'd3};
        reg_image[CFG_ZERO]         = {16'd1, 16'd1};
        reg_image[CFG_ONE]          = {16'd1, 16'd2};
        reg_image[CFG_REPEAT_START] = {16'd3, 16'd1};
        reg_image[CFG_REPEAT_STOP]  = {16'd1, 16'd4};
        program_regs();
        send_req(REQ_LOAD, 5'd0, 8'hFF, 16'h0000);
        send_req(REQ_LOAD, 5'd1, 8'h00, 16'hFFFF);
        send_req(REQ_LOAD, 5'd2, 8'hA5, 16'h5A5A);
        send_req(REQ_LOAD, 5'd3, 8'h3C, 16'hA5A5);
        send_req(REQ_LOAD, 5'd31, 8'h5A, 16'h0000);
        send_kind(REQ_TICK);
        for (int k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++)
            send_kind(3'(k));
        send_req(REQ_TRANSMIT, 5'd31, 8'hFF, 16'hFFFF);
        send_kind(REQ_TICK);
        // starts while the frame runs are dropped
        send_kind(REQ_TRANSMIT);
        send_kind(REQ_REPEAT);
        send_req(REQ_DELAY, 5'd0, 8'h00, 16'hFFFF);
        // load while busy, into a byte not yet latched
        send_req(REQ_LOAD, 5'd3, 8'hC3, 16'h0000);
        run_out_frame();
        send_kind(REQ_REPEAT);
        run_out_frame();
        send_req(REQ_DELAY, 5'd0, 8'h00, 16'h0000);
        run_out_frame();
        send_req(REQ_DELAY, 5'd0, 8'h00, 16'd5);
        run_out_frame();
    endtask

    // every code byte written, so any bit count is safe to send
    task automatic test_code_store_fill();
        for (int i = 0; i < CODE_BYTES; i++)
            send_req(REQ_LOAD, i[4:0], 8'($urandom_range(255)), 16'($urandom_range(65535)));
    endtask

    // zero-space marks and a gate left on by zero-mark pairs
    task automatic test_gate_corners();
        settle_framer();
        reg_image[CFG_BIT_COUNT]    = 32'd4;
        reg_image[CFG_START]        = {16'd1, 16'd1};
        reg_image[CFG_STOP]         = {16'd2, 16'd0};
        reg_image[CFG_ZERO]         = {16'd3, 16'd0};
        reg_image[CFG_ONE]          = {16'd0, 16'd2};
        reg_image[CFG_REPEAT_START] = {16'd0, 16'd0};
        reg_image[CFG_REPEAT_STOP]  = {16'd4, 16'd0};
        program_regs();
        send_req(REQ_LOAD, 5'd0, 8'h06, 16'd0);
        send_kind(REQ_TRANSMIT);
        send_kind(REQ_TICK);
        send_kind(REQ_TRANSMIT);
        send_req(REQ_LOAD, 5'd9, 8'h81, 16'd0);
        run_out_frame();
        send_kind(REQ_REPEAT);
        run_out_frame();
        send_req(REQ_DELAY, 5'd0, 8'h00, 16'd3);
        run_out_frame();
    endtask

    task automatic test_random_traffic(input int segments);
        for (int seg = 0; seg < segments; seg++)
        begin
            settle_framer();
            pick_random_timings();
            program_regs();
            run_random_items(SEG_ITEMS);
        end
    endtask

    // result side stalls long while requests keep coming
    task automatic test_backpressure();
        int saved_pct;
        settle_framer();
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        hold_off_len = 300;
        send_kind(REQ_TRANSMIT);
        for (int i = 0; i < 40; i++)
            send_kind(REQ_TICK);
        send_idle_pct = saved_pct;
        settle_framer();
    endtask

    // all-zero timings at the largest bit count, then a frame with no data bits
    task automatic test_timing_extremes();
        settle_framer();
        reg_image[CFG_BIT_COUNT] = 32'd255;
        for (int i = CFG_START; i <= CFG_REPEAT_STOP; i++)
            reg_image[i] = 32'd0;
        program_regs();
        send_kind(REQ_TRANSMIT);
        run_out_frame();
        send_kind(REQ_REPEAT);
        run_out_frame();
        settle_framer();
        reg_image[CFG_BIT_COUNT] = 32'd0;
        reg_image[CFG_START]     = {16'd5, 16'd9};
        reg_image[CFG_STOP]      = {16'd1, 16'd1};
        program_regs();
        send_kind(REQ_TRANSMIT);
        run_out_frame();
    endtask

    task automatic test_long_delay();
        settle_framer();
        send_req(REQ_DELAY, 5'd0, 8'h00, 16'd120);
        run_out_frame();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 32'd0;
        s_tuser        = REQ_TICK;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BIT_COUNT;
        cfg_wdata      = 32'd0;
        hold_off_len   = 0;
        mismatch_count = 0;
        send_idle_pct  = 32;
        recv_idle_pct  = 82;
        reset_emitter_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frames();
        test_code_store_fill();
        test_gate_corners();
        test_random_traffic(2);

        send_idle_pct = 82;
        recv_idle_pct = 32;
        test_random_traffic(2);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(2);
        test_timing_extremes();
        test_long_delay();

        settle_framer();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_ir_pulse_distance_transmitter_core: PASS");
        else
            $display("tb_ir_pulse_distance_transmitter_core: FAIL");
        $finish;
    end

endmodule

[ir_pulse_distance_transmitter_core.f]
rtl/irpdt_pkg.sv
rtl/irpdt_ram.sv
rtl/ir_pulse_distance_transmitter_core.sv
tb/tb_ir_pulse_distance_transmitter_core.sv
